[src/pcrh_pkg.sv]
package pcrh_pkg;

  // Configuration register indexes.
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_FORMAT   = 2'd0;
  localparam cfg_idx_t REG_CHANNELS = 2'd1;
  localparam cfg_idx_t REG_SRC_RATE = 2'd2;

  localparam int CFG_DATA_W = 18;
  localparam int CHAN_W     = 4;
  localparam int FRAME_W    = 5;
  localparam int SKIP_W     = 7;
  localparam int SAMPLE_W   = 16;
  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 4;

  localparam logic [SKIP_W-1:0] SKIP_MAX  = 7'd127;
  localparam logic [CNT_W-1:0]  CNT_LAST  = 4'd15;

  localparam logic                  RST_FORMAT   = 1'b1;
  localparam logic [CHAN_W-1:0]     RST_CHANNELS = 4'd1;
  localparam logic [CFG_DATA_W-1:0] RST_SRC_RATE = 18'd48000;

  // Sample format codes.
  localparam logic FMT_S8    = 1'b0;
  localparam logic FMT_S16LE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic load;       // input item accepted
    logic emit_step;  // output item accepted
    logic div_step;   // one quotient iteration
  } cmd_t;

  typedef struct packed {
    logic sel;        // current input byte completes a sample
    logic last;       // current output is the final one for this sample
    logic div_more;   // remainder still at or above the output rate
  } stat_t;

endpackage

[src/pcm_rate_converter_hold.sv]
// Zero-order-hold rate converter: raw interleaved PCM bytes in, mono signed 16-bit samples
// out at OUTPUT_RATE, using channel zero only. A byte that completes no sample is taken
// without a stall. A byte that completes a sample stalls the input while that sample is
// sent between 1 and 16 times, one output item per cycle while m_axis_tready is high; the
// phase wrap is then resolved by one subtract-and-compare unit, which takes OUTPUT_RATE
// off the remainder and advances the input byte skip by one frame while the remainder is
// at or above OUTPUT_RATE. Input is accepted again once that pass ends.
// Configuration writes are taken at any cycle and must only be issued while the block
// is idle.
module pcm_rate_converter_hold #(
  parameter int OUTPUT_RATE = 48000
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  pcrh_pkg::cfg_idx_t               cfg_index_i,
  input  logic [pcrh_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [7:0] data_byte
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [15:0]                      m_axis_tdata,  // [15:0] sample
  output logic                             m_axis_tlast
);

  pcrh_pkg::cmd_t  cmd;
  pcrh_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  pcrh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pcrh_datapath #(
    .OUTPUT_RATE (OUTPUT_RATE)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_data_i    (s_axis_tdata),
    .out_sample_o (m_axis_tdata),
    .out_last_o   (m_axis_tlast),
    .cmd_i        (cmd),
    .stat_o       (stat)
  );

endmodule

[src/pcrh_datapath.sv]
module pcrh_datapath #(
  parameter int OUTPUT_RATE = 48000
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  pcrh_pkg::cfg_idx_t                  cfg_index_i,
  input  logic [pcrh_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [pcrh_pkg::BYTE_W-1:0]         in_data_i,
  output logic [pcrh_pkg::SAMPLE_W-1:0]       out_sample_o,
  output logic                                out_last_o,
  input  pcrh_pkg::cmd_t                      cmd_i,
  output pcrh_pkg::stat_t                     stat_o
);

  localparam int PH_W    = $clog2(OUTPUT_RATE);
  localparam int SUM_MAX = OUTPUT_RATE - 1 + (2 ** pcrh_pkg::CFG_DATA_W) - 1;
  localparam int ACC_W   = $clog2(SUM_MAX + 1);
  localparam logic [ACC_W-1:0] RATE_ACC = ACC_W'(OUTPUT_RATE);

  logic                              fmt_q;
  logic [pcrh_pkg::CHAN_W-1:0]       chan_q;
  logic [pcrh_pkg::CFG_DATA_W-1:0]   src_q;

  logic [pcrh_pkg::SKIP_W-1:0]       skip_q;
  logic [PH_W-1:0]                   phase_q;
  logic [pcrh_pkg::BYTE_W-1:0]       held_q;
  logic                              have_q;
  logic [pcrh_pkg::SAMPLE_W-1:0]     value_q;
  logic [pcrh_pkg::CNT_W-1:0]        cnt_q;
  logic [ACC_W-1:0]                  rem_q;

  logic [pcrh_pkg::CHAN_W-1:0]       ch;
  logic [pcrh_pkg::FRAME_W-1:0]      frame;
  logic [pcrh_pkg::FRAME_W-1:0]      first_skip;
  logic [ACC_W-1:0]                  acc;
  logic                              reached;
  logic [pcrh_pkg::SKIP_W:0]         skip_sum;
  logic [pcrh_pkg::SKIP_W-1:0]       skip_sat;

  always_comb begin
    ch = (chan_q == '0) ? pcrh_pkg::CHAN_W'(1) : chan_q;
    if (fmt_q == pcrh_pkg::FMT_S16LE) begin
      frame = {ch, 1'b0};
    end else begin
      frame = {1'b0, ch};
    end
    // The first quotient step advances one frame minus the bytes of the sample.
    if (fmt_q == pcrh_pkg::FMT_S16LE) begin
      first_skip = frame - pcrh_pkg::FRAME_W'(2);
    end else begin
      first_skip = frame - pcrh_pkg::FRAME_W'(1);
    end
    acc      = ACC_W'(phase_q) + ACC_W'(src_q);
    reached  = (acc >= RATE_ACC);
    skip_sum = {1'b0, skip_q} + (pcrh_pkg::SKIP_W + 1)'(frame);
    skip_sat = (skip_sum > (pcrh_pkg::SKIP_W + 1)'(pcrh_pkg::SKIP_MAX)) ?
               pcrh_pkg::SKIP_MAX : skip_sum[pcrh_pkg::SKIP_W-1:0];
  end

  always_comb begin
    if (fmt_q == pcrh_pkg::FMT_S8) begin
      stat_o.sel = (skip_q == '0);
    end else begin
      stat_o.sel = have_q;
    end
    stat_o.last     = reached || (cnt_q == pcrh_pkg::CNT_LAST);
    stat_o.div_more = (rem_q >= RATE_ACC);
  end

  assign out_sample_o = value_q;
  assign out_last_o   = stat_o.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q  <= pcrh_pkg::RST_FORMAT;
      chan_q <= pcrh_pkg::RST_CHANNELS;
      src_q  <= pcrh_pkg::RST_SRC_RATE;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pcrh_pkg::REG_FORMAT:   fmt_q  <= cfg_data_i[0];
        pcrh_pkg::REG_CHANNELS: chan_q <= cfg_data_i[pcrh_pkg::CHAN_W-1:0];
        pcrh_pkg::REG_SRC_RATE: src_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q  <= '0;
      phase_q <= '0;
      held_q  <= '0;
      have_q  <= 1'b0;
      cnt_q   <= '0;
      rem_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= '0;
        if (fmt_q == pcrh_pkg::FMT_S8) begin
          have_q <= 1'b0;
          if (skip_q != '0) begin
            skip_q <= skip_q - pcrh_pkg::SKIP_W'(1);
          end
        end else if (have_q) begin
          have_q <= 1'b0;
        end else if (skip_q != '0) begin
          skip_q <= skip_q - pcrh_pkg::SKIP_W'(1);
        end else begin
          held_q <= in_data_i;
          have_q <= 1'b1;
        end
      end
      if (cmd_i.emit_step) begin
        if (stat_o.last) begin
          // Without a wrap the sample still ends, and the phase keeps the sum.
          rem_q  <= reached ? (acc - RATE_ACC) : acc;
          skip_q <= pcrh_pkg::SKIP_W'(first_skip);
        end else begin
          phase_q <= PH_W'(acc);
          cnt_q   <= cnt_q + pcrh_pkg::CNT_W'(1);
        end
      end
      if (cmd_i.div_step) begin
        if (stat_o.div_more) begin
          rem_q  <= rem_q - RATE_ACC;
          skip_q <= skip_sat;
        end else begin
          phase_q <= PH_W'(rem_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (fmt_q == pcrh_pkg::FMT_S8) begin
        value_q <= {in_data_i, 8'h00};
      end else begin
        value_q <= {in_data_i, held_q};
      end
    end
  end

  phase_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ACC_W'(phase_q) < RATE_ACC)
    else $error("phase accumulator reached the output rate");

endmodule

[src/pcrh_ctrl.sv]
module pcrh_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  pcrh_pkg::stat_t  stat_i,
  output pcrh_pkg::cmd_t   cmd_o
);

  pcrh_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      pcrh_pkg::ST_IDLE: begin
        if (in_valid_i && stat_i.sel) begin
          state_d = pcrh_pkg::ST_EMIT;
        end
      end
      pcrh_pkg::ST_EMIT: begin
        if (out_ready_i && stat_i.last) begin
          state_d = pcrh_pkg::ST_DIV;
        end
      end
      pcrh_pkg::ST_DIV: begin
        if (!stat_i.div_more) begin
          state_d = pcrh_pkg::ST_IDLE;
        end
      end
      default: state_d = pcrh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    out_valid_o     = 1'b0;
    cmd_o           = '0;
    case (state_q)
      pcrh_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      pcrh_pkg::ST_EMIT: begin
        out_valid_o     = 1'b1;
        cmd_o.emit_step = out_ready_i;
      end
      pcrh_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcrh_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output side active together");

  last_ends_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && stat_i.last) |=> (state_q == pcrh_pkg::ST_DIV))
    else $error("final output did not start the quotient pass");

  div_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pcrh_pkg::ST_DIV && !stat_i.div_more) |=> in_ready_o)
    else $error("quotient pass did not return to idle");

  emit_needs_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !stat_i.sel) |=> in_ready_o)
    else $error("unselected byte started an emission");

endmodule
